// ===== sv/pqls_pkg.sv =====
// Package for the priority queue over LIFO scheduler.
// Field widths, store sizes, command and status codes, entry types.
// No dependencies; used by every module of the block.
package pqls_pkg;

  // Store sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int STACK_DEPTH = 16;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);

  // Field widths
  localparam int OP_W   = 2;
  localparam int TAG_W  = 16;
  localparam int URG_W  = 8;
  localparam int TIME_W = 11;
  localparam int ST_W   = 3;

  // Opcodes on the input side
  localparam logic [OP_W-1:0] OP_PUSH      = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVE     = 2'd2;
  localparam logic [OP_W-1:0] OP_SERVE_ALT = 2'd3;

  // Classified command kind
  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_INSERT,
    KIND_SERVE
  } kind_t;

  // Result status
  typedef enum logic [ST_W-1:0] {
    ST_LANDED   = 3'd0,
    ST_DEPARTED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Command passed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [URG_W-1:0]   urg;
    logic [TIME_W-1:0]  minute;
  } cmd_t;

  // Sorted arrival queue entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [URG_W-1:0]   urg;
    logic [TIME_W-1:0]  minute;
  } qentry_t;

  // Departure stack entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  minute;
  } sentry_t;

endpackage

// ===== sv/pqls_front.sv =====
// Front end: accepts input beats, decodes the opcode into a command kind
// and buffers commands in a two-entry FIFO toward the back end. Uses pqls_pkg.
module pqls_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pqls_pkg::OP_W-1:0]    opcode,
  input  logic [pqls_pkg::TAG_W-1:0]   flight_tag,
  input  logic [pqls_pkg::URG_W-1:0]   urgency,
  input  logic [pqls_pkg::TIME_W-1:0]  event_time,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output pqls_pkg::cmd_t               cmd
);

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  pqls_pkg::cmd_t     fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   fcount, fcount_next;
  pqls_pkg::kind_t    kind;
  logic               push, pop;

  // Opcode decode; the high opcode bit alone selects serve
  always_comb begin
    unique case (opcode) inside
      pqls_pkg::OP_PUSH:                         kind = pqls_pkg::KIND_PUSH;
      pqls_pkg::OP_INSERT:                       kind = pqls_pkg::KIND_INSERT;
      pqls_pkg::OP_SERVE, pqls_pkg::OP_SERVE_ALT: kind = pqls_pkg::KIND_SERVE;
      default:                                   kind = pqls_pkg::KIND_SERVE;
    endcase
  end

  // Handshakes
  assign in_ready  = (fcount != CNT_W'(FIFO_DEPTH));
  assign cmd_valid = (fcount != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo_mem[rd_ptr];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fcount_next = fcount;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      fcount_next = fcount + 1'b1;
    end else if (pop && !push) begin
      fcount_next = fcount - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcount <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fcount <= fcount_next;
    end
  end

  // FIFO storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{kind: kind, tag: flight_tag, urg: urgency, minute: event_time};
    end
  end

  // Fill level never exceeds the FIFO size
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= CNT_W'(FIFO_DEPTH))
    else $error("command FIFO overfilled");

endmodule

// ===== sv/pqls_back.sv =====
// Back end: executes commands against the sorted arrival queue (shift cells)
// and the departure stack (memory with cached top), registers one result.
// Uses pqls_pkg.
module pqls_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  pqls_pkg::cmd_t                cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pqls_pkg::status_t             status,
  output logic [pqls_pkg::TAG_W-1:0]    served_tag,
  output logic [pqls_pkg::URG_W-1:0]    served_urgency,
  output logic [pqls_pkg::TIME_W-1:0]   served_time
);

  localparam int QD = pqls_pkg::QUEUE_DEPTH;
  localparam int SD = pqls_pkg::STACK_DEPTH;

  // Arrival queue cells, slot 0 is the head
  pqls_pkg::qentry_t                cells      [QD];
  pqls_pkg::qentry_t                cells_next [QD];
  logic [pqls_pkg::QCNT_W-1:0]      qcount, qcount_next;
  logic [QD-1:0]                    take;
  pqls_pkg::qentry_t                new_q;

  // Departure stack memory and registered top
  pqls_pkg::sentry_t                stack_mem [SD];
  pqls_pkg::sentry_t                top_q;
  pqls_pkg::sentry_t                s_wdata;
  logic                             s_we;
  logic [pqls_pkg::SIDX_W-1:0]      s_waddr, s_raddr;
  logic [pqls_pkg::SCNT_W-1:0]      scount, scount_next, s_rsum;

  // Result staging
  logic                             exec;
  pqls_pkg::status_t                status_next;
  logic [pqls_pkg::TAG_W-1:0]       tag_next;
  logic [pqls_pkg::URG_W-1:0]       urg_next;
  logic [pqls_pkg::TIME_W-1:0]      time_next;

  assign cmd_ready = !res_valid || res_ready;
  assign exec      = cmd_valid && cmd_ready;
  assign new_q     = '{tag: cmd.tag, urg: cmd.urg, minute: cmd.minute};
  assign s_wdata   = '{tag: cmd.tag, minute: cmd.minute};
  assign s_waddr   = scount[pqls_pkg::SIDX_W-1:0];
  assign s_rsum    = scount_next - pqls_pkg::SCNT_W'(1);
  assign s_raddr   = s_rsum[pqls_pkg::SIDX_W-1:0];

  // Parallel compare: a cell at or past the insert point is empty or
  // holds a strictly lower urgency
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      take[i] = (pqls_pkg::QCNT_W'(i) >= qcount) || (cmd.urg > cells[i].urg);
    end
  end

  // Command execution
  always_comb begin
    cells_next  = cells;
    qcount_next = qcount;
    scount_next = scount;
    s_we        = 1'b0;
    status_next = pqls_pkg::ST_EMPTY;
    tag_next    = '0;
    urg_next    = '0;
    time_next   = '0;
    if (exec) begin
      unique case (cmd.kind)
        pqls_pkg::KIND_SERVE: begin
          if (qcount != '0) begin
            for (int i = 0; i < QD - 1; i++) begin
              cells_next[i] = cells[i + 1];
            end
            qcount_next = qcount - 1'b1;
            status_next = pqls_pkg::ST_LANDED;
            tag_next    = cells[0].tag;
            urg_next    = cells[0].urg;
            time_next   = cells[0].minute;
          end else if (scount != '0) begin
            scount_next = scount - 1'b1;
            status_next = pqls_pkg::ST_DEPARTED;
            tag_next    = top_q.tag;
            time_next   = top_q.minute;
          end
        end
        pqls_pkg::KIND_PUSH: begin
          if (scount == pqls_pkg::SCNT_W'(SD)) begin
            status_next = pqls_pkg::ST_FULL;
          end else begin
            s_we        = 1'b1;
            scount_next = scount + 1'b1;
            status_next = pqls_pkg::ST_ACCEPTED;
          end
        end
        pqls_pkg::KIND_INSERT: begin
          if (qcount == pqls_pkg::QCNT_W'(QD)) begin
            status_next = pqls_pkg::ST_FULL;
          end else begin
            if (take[0]) begin
              cells_next[0] = new_q;
            end
            for (int i = 1; i < QD; i++) begin
              if (take[i]) begin
                cells_next[i] = take[i - 1] ? cells[i - 1] : new_q;
              end
            end
            qcount_next = qcount + 1'b1;
            status_next = pqls_pkg::ST_ACCEPTED;
          end
        end
        default: begin
          status_next = pqls_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  // Counts and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      qcount    <= '0;
      scount    <= '0;
      res_valid <= 1'b0;
    end else begin
      qcount <= qcount_next;
      scount <= scount_next;
      if (exec) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Queue cells and result payload
  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (exec) begin
      status         <= status_next;
      served_tag     <= tag_next;
      served_urgency <= urg_next;
      served_time    <= time_next;
    end
  end

  // Stack memory; top read is registered with write-first bypass
  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    top_q <= (s_we && (s_waddr == s_raddr)) ? s_wdata : stack_mem[s_raddr];
  end

  // Checks
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= pqls_pkg::QCNT_W'(QD))
    else $error("arrival count beyond queue depth");

  a_scount_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= pqls_pkg::SCNT_W'(SD))
    else $error("departure count beyond stack depth");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (qcount >= pqls_pkg::QCNT_W'(2)) |-> (cells[0].urg >= cells[1].urg))
    else $error("queue head out of urgency order");

  a_land_pops: assert property (@(posedge clk) disable iff (rst)
    (exec && (cmd.kind == pqls_pkg::KIND_SERVE) && (qcount != '0))
      |=> (qcount == $past(qcount) - 1'b1) && (status == pqls_pkg::ST_LANDED))
    else $error("serve with waiting arrivals did not land one");

endmodule

// ===== sv/priority_queue_over_lifo_scheduler_top.sv =====
// Top level of the priority queue over LIFO scheduler: stream ports,
// field packing, front end (pqls_front) and back end (pqls_back). Uses pqls_pkg.
//
// Each input beat pushes a departure onto a LIFO stack, inserts an arrival
// into a stable urgency-sorted queue, or asks for service (queue head first,
// then stack top), and yields exactly one result beat. The block takes one
// beat per cycle unless the output stalls: the back end executes any command
// with no busy state, comparing the new urgency against all queue cells in
// parallel and keeping the stack top in a register refreshed from the stack
// memory each cycle. An accepted input beat is held in the two-entry command
// FIFO, and its result in the output register. When the output is stalled
// the FIFO absorbs two more beats before s_tready drops. No clearing pass is
// needed after reset.
module priority_queue_over_lifo_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // flight_tag[15:0], urgency[23:16], event_time[34:24], zero
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // served_tag[15:0], served_urgency[23:16],
                                // served_time[34:24], zero
  output logic [2:0]  m_tuser   // status[2:0]
);

  logic                              cmd_valid, cmd_ready;
  pqls_pkg::cmd_t                    cmd;
  pqls_pkg::status_t                 status;
  logic [pqls_pkg::TAG_W-1:0]        served_tag;
  logic [pqls_pkg::URG_W-1:0]        served_urgency;
  logic [pqls_pkg::TIME_W-1:0]       served_time;

  // Decode and buffer
  pqls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .flight_tag (s_tdata[15:0]),
    .urgency    (s_tdata[23:16]),
    .event_time (s_tdata[34:24]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Execute against the stores
  pqls_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .status         (status),
    .served_tag     (served_tag),
    .served_urgency (served_urgency),
    .served_time    (served_time)
  );

  // Result packing
  assign m_tdata = {5'b0, served_time, served_urgency, served_tag};
  assign m_tuser = status;

endmodule
